// ----- rtl/core/encoder_angle_unwrap_stall_defines.svh -----
// Assertion macros shared by the encoder angle unwrapper.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ENCODER_ANGLE_UNWRAP_STALL_DEFINES_SVH
`define ENCODER_ANGLE_UNWRAP_STALL_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EAUS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EAUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/eaus_pkg.sv -----
package eaus_pkg;

    // Fixed field widths.
    localparam int ANGLE_W    = 17;
    localparam int POS_W      = 32;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 31;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Default parameter values.
    localparam int ANGLE_FRACTION_BITS_DEF = 8;
    localparam int ADC_BITS_DEF            = 12;

    // Register reset values.
    localparam int unsigned MIN_SPAN_RESET = 100;
    localparam logic [TIME_W-1:0] STALL_TIMEOUT_RESET = 32'd1000;
    localparam logic [THR_W-1:0] MOVE_THRESHOLD_RESET = 31'd23040;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_SPAN       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STALL_TIMEOUT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MOVE_THRESHOLD = 2'd2;

    // One sample after the input register, with stability already decided.
    typedef struct packed {
        logic               restart;
        logic               stable;
        logic [ANGLE_W-1:0] angle;
        logic [TIME_W-1:0]  now_ms;
    } sample_t;

    // Settings used by the stall detector.
    typedef struct packed {
        logic [TIME_W-1:0] timeout;
        logic [THR_W-1:0]  threshold;
    } stall_cfg_t;

endpackage

// ----- rtl/core/encoder_angle_unwrap_stall.sv -----
// A sample passes the input register and then the result register before its result is
// offered. Throughput: one item per cycle while out_ready is not held low.
// An input register and a result register part the two sides, so a result may wait
// while the next sample is taken.
// Reset (asynchronous, active low) clears both stages, sets the reference as awaited
// and loads the register defaults; it takes effect at once with no clearing pass.
`include "encoder_angle_unwrap_stall_defines.svh"

module encoder_angle_unwrap_stall #(
    parameter int ANGLE_FRACTION_BITS = eaus_pkg::ANGLE_FRACTION_BITS_DEF,
    parameter int ADC_BITS            = eaus_pkg::ADC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [eaus_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [eaus_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               restart,
    input  logic [eaus_pkg::ANGLE_W-1:0]       angle,
    input  logic                               bounds_valid,
    input  logic [ADC_BITS-1:0]                sine_min,
    input  logic [ADC_BITS-1:0]                sine_max,
    input  logic [ADC_BITS-1:0]                cosine_min,
    input  logic [ADC_BITS-1:0]                cosine_max,
    input  logic [eaus_pkg::TIME_W-1:0]        now_ms,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [eaus_pkg::POS_W-1:0]  unwrapped_position,
    output logic                               stall_res,
    output logic                               awaiting_reference
);

    logic [ADC_BITS-1:0]  min_span;
    eaus_pkg::stall_cfg_t stall_cfg;
    logic                 advance;
    logic                 s1_valid;
    eaus_pkg::sample_t    sample;
    logic                 take;

    // Configuration registers.
    eaus_cfg_regs #(
        .ADC_BITS (ADC_BITS)
    ) u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .min_span  (min_span),
        .stall_cfg (stall_cfg)
    );

    // Stability check and input register.
    eaus_input_stage #(
        .ADC_BITS (ADC_BITS)
    ) u_input_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .restart      (restart),
        .angle        (angle),
        .bounds_valid (bounds_valid),
        .sine_min     (sine_min),
        .sine_max     (sine_max),
        .cosine_min   (cosine_min),
        .cosine_max   (cosine_max),
        .now_ms       (now_ms),
        .min_span     (min_span),
        .advance      (advance),
        .s1_valid     (s1_valid),
        .sample       (sample)
    );

    // Unwrapping, stall detection and result register.
    eaus_tracker #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_tracker (
        .clk                (clk),
        .rst_n              (rst_n),
        .s1_valid           (s1_valid),
        .sample             (sample),
        .stall_cfg          (stall_cfg),
        .out_ready          (out_ready),
        .advance            (advance),
        .out_valid          (out_valid),
        .unwrapped_position (unwrapped_position),
        .stall_res          (stall_res),
        .awaiting_reference (awaiting_reference)
    );

    assign take = s1_valid && advance;

    // A sample moving into the tracker always yields a result in the next cycle.
    `EAUS_ASSERT_NEXT(a_take_gives_result, take, out_valid, "sample lost in the tracker")

    // A restarted sample has just moved, so it can never report a stall.
    `EAUS_ASSERT_NEXT(a_restart_no_stall, take && sample.restart, !stall_res, "stall on restart")

    // The total is held at zero until a reference has been taken.
    `EAUS_ASSERT_SAME(a_waiting_zero_total, out_valid && awaiting_reference, unwrapped_position == '0, "non-zero total while waiting")

    // Whenever the output side takes a transfer, the input side is open.
    `EAUS_ASSERT_SAME(a_ready_follows, out_ready, in_ready, "input stalled while output drains")

endmodule

// ----- rtl/core/eaus_cfg_regs.sv -----
module eaus_cfg_regs #(
    parameter int ADC_BITS = eaus_pkg::ADC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [eaus_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [eaus_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [ADC_BITS-1:0]              min_span,
    output eaus_pkg::stall_cfg_t             stall_cfg
);

    logic [ADC_BITS-1:0]        min_span_reg;
    eaus_pkg::stall_cfg_t       stall_cfg_reg;

    // The register file can take a write in every cycle.
    assign cfg_ready = 1'b1;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_span_reg            <= ADC_BITS'(eaus_pkg::MIN_SPAN_RESET);
            stall_cfg_reg.timeout   <= eaus_pkg::STALL_TIMEOUT_RESET;
            stall_cfg_reg.threshold <= eaus_pkg::MOVE_THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                eaus_pkg::REG_MIN_SPAN:
                    min_span_reg <= cfg_data[ADC_BITS-1:0];
                eaus_pkg::REG_STALL_TIMEOUT:
                    stall_cfg_reg.timeout <= cfg_data[eaus_pkg::TIME_W-1:0];
                eaus_pkg::REG_MOVE_THRESHOLD:
                    stall_cfg_reg.threshold <= cfg_data[eaus_pkg::THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign min_span  = min_span_reg;
    assign stall_cfg = stall_cfg_reg;

endmodule

// ----- rtl/core/eaus_input_stage.sv -----
module eaus_input_stage #(
    parameter int ADC_BITS = eaus_pkg::ADC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    input  logic [eaus_pkg::ANGLE_W-1:0]  angle,
    input  logic                          bounds_valid,
    input  logic [ADC_BITS-1:0]           sine_min,
    input  logic [ADC_BITS-1:0]           sine_max,
    input  logic [ADC_BITS-1:0]           cosine_min,
    input  logic [ADC_BITS-1:0]           cosine_max,
    input  logic [eaus_pkg::TIME_W-1:0]   now_ms,
    input  logic [ADC_BITS-1:0]           min_span,
    input  logic                          advance,
    output logic                          s1_valid,
    output eaus_pkg::sample_t             sample
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    eaus_pkg::sample_t sample_reg;
    logic              sine_ok;
    logic              cosine_ok;
    logic              in_xfer;

    // A span is stable only when max lies above min by more than min_span.
    // An inverted pair is never stable, so the subtraction cannot wrap.
    assign sine_ok   = (sine_max > sine_min) && ((sine_max - sine_min) > min_span);
    assign cosine_ok = (cosine_max > cosine_min) && ((cosine_max - cosine_min) > min_span);

    // The stage takes a new sample when empty or when its sample moves on.
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Sample payload register.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg.restart <= restart;
            sample_reg.stable  <= bounds_valid && sine_ok && cosine_ok;
            sample_reg.angle   <= angle;
            sample_reg.now_ms  <= now_ms;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign sample   = sample_reg;

endmodule

// ----- rtl/core/eaus_tracker.sv -----
module eaus_tracker #(
    parameter int ANGLE_FRACTION_BITS = eaus_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s1_valid,
    input  eaus_pkg::sample_t                  sample,
    input  eaus_pkg::stall_cfg_t               stall_cfg,
    input  logic                               out_ready,
    output logic                               advance,
    output logic                               out_valid,
    output logic signed [eaus_pkg::POS_W-1:0]  unwrapped_position,
    output logic                               stall_res,
    output logic                               awaiting_reference
);

    localparam int ANGLE_W   = eaus_pkg::ANGLE_W;
    localparam int POS_W     = eaus_pkg::POS_W;
    localparam int TIME_W    = eaus_pkg::TIME_W;
    localparam int HALF_TURN = 180 << ANGLE_FRACTION_BITS;
    localparam int FULL_TURN = 360 << ANGLE_FRACTION_BITS;
    localparam int DELTA_W   = $clog2(FULL_TURN + (1 << ANGLE_W)) + 1;

    localparam logic signed [DELTA_W-1:0] HALF_C     = DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W-1:0] NEG_HALF_C = -DELTA_W'(HALF_TURN);
    localparam logic signed [DELTA_W-1:0] FULL_C     = DELTA_W'(FULL_TURN);
    localparam logic signed [POS_W-1:0]   POS_MAX    = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]   POS_MIN    = {1'b1, {(POS_W-1){1'b0}}};

    // Tracker state.
    logic [ANGLE_W-1:0]      prev_angle_reg;
    logic [ANGLE_W-1:0]      prev_angle_next;
    logic                    waiting_reg;
    logic                    waiting_next;
    logic signed [POS_W-1:0] total_reg;
    logic signed [POS_W-1:0] total_next;
    logic [TIME_W-1:0]       move_time_reg;
    logic [TIME_W-1:0]       move_time_next;
    logic signed [POS_W-1:0] move_pos_reg;
    logic signed [POS_W-1:0] move_pos_next;

    // Result register.
    logic                    out_valid_reg;
    logic signed [POS_W-1:0] position_reg;
    logic                    stall_reg;
    logic                    stall_next;
    logic                    awaiting_reg;

    // State as seen after a restart has been applied.
    logic [ANGLE_W-1:0]      prev_eff;
    logic                    waiting_eff;
    logic signed [POS_W-1:0] total_eff;
    logic [TIME_W-1:0]       move_time_eff;
    logic signed [POS_W-1:0] move_pos_eff;

    logic signed [DELTA_W-1:0] delta_raw;
    logic signed [DELTA_W-1:0] delta_fold;
    logic signed [POS_W:0]     sum;
    logic signed [POS_W-1:0]   sum_sat;
    logic signed [POS_W:0]     diff;
    logic [POS_W:0]            diff_abs;
    logic                      moved;
    logic                      take;

    // The result register frees up when empty or when its result is taken.
    assign advance = !out_valid_reg || out_ready;
    assign take    = s1_valid && advance;

    // A restart re-zeroes the tracker before the sample is considered.
    always_comb
    begin
        if (sample.restart)
        begin
            prev_eff      = sample.angle;
            waiting_eff   = 1'b1;
            total_eff     = '0;
            move_time_eff = sample.now_ms;
            move_pos_eff  = '0;
        end
        else
        begin
            prev_eff      = prev_angle_reg;
            waiting_eff   = waiting_reg;
            total_eff     = total_reg;
            move_time_eff = move_time_reg;
            move_pos_eff  = move_pos_reg;
        end
    end

    // Shortest-path delta, folded once at plus or minus half a turn.
    always_comb
    begin
        delta_raw = $signed({{(DELTA_W-ANGLE_W){1'b0}}, sample.angle})
                  - $signed({{(DELTA_W-ANGLE_W){1'b0}}, prev_eff});
        if (delta_raw > HALF_C)
        begin
            delta_fold = delta_raw - FULL_C;
        end
        else if (delta_raw < NEG_HALF_C)
        begin
            delta_fold = delta_raw + FULL_C;
        end
        else
        begin
            delta_fold = delta_raw;
        end
    end

    // Saturating accumulation into the running total.
    always_comb
    begin
        sum = $signed({total_eff[POS_W-1], total_eff}) + (POS_W+1)'(delta_fold);
        if (sum[POS_W] != sum[POS_W-1])
        begin
            sum_sat = sum[POS_W] ? POS_MIN : POS_MAX;
        end
        else
        begin
            sum_sat = sum[POS_W-1:0];
        end
    end

    // Reference handling: unstable samples only refresh the angle while waiting.
    always_comb
    begin
        prev_angle_next = (waiting_eff || sample.stable) ? sample.angle : prev_eff;
        waiting_next    = waiting_eff && !sample.stable;
        total_next      = (sample.stable && !waiting_eff) ? sum_sat : total_eff;
    end

    // Movement check against the last point at which motion was seen.
    always_comb
    begin
        diff     = $signed({total_next[POS_W-1], total_next})
                 - $signed({move_pos_eff[POS_W-1], move_pos_eff});
        diff_abs = diff[POS_W] ? $unsigned(-diff) : $unsigned(diff);
        moved    = diff_abs > {2'b00, stall_cfg.threshold};
        move_pos_next  = moved ? total_next : move_pos_eff;
        move_time_next = moved ? sample.now_ms : move_time_eff;
        stall_next     = (sample.now_ms - move_time_next) > stall_cfg.timeout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg <= '0;
            waiting_reg    <= 1'b1;
            total_reg      <= '0;
            move_time_reg  <= '0;
            move_pos_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                prev_angle_reg <= prev_angle_next;
                waiting_reg    <= waiting_next;
                total_reg      <= total_next;
                move_time_reg  <= move_time_next;
                move_pos_reg   <= move_pos_next;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            position_reg <= total_next;
            stall_reg    <= stall_next;
            awaiting_reg <= waiting_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign unwrapped_position = position_reg;
    assign stall_res          = stall_reg;
    assign awaiting_reference = awaiting_reg;

endmodule
